/* hw/rtl/spimb_pkg.sv */
`timescale 1ns / 1ps

package spimb_pkg;

    // Default shift word width
    localparam int WORD_BITS_DEF = 8;

    // Input actions (s_tuser)
    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_START    = 2'd1,
        ACT_SELECT   = 2'd2,
        ACT_DESELECT = 2'd3
    } action_t;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_SPI_MODE       = 3'd0;
    localparam logic [2:0] REG_LSB_FIRST      = 3'd1;
    localparam logic [2:0] REG_PHASE_WAIT     = 3'd2;
    localparam logic [2:0] REG_CS_ACTIVE_HIGH = 3'd3;
    localparam logic [2:0] REG_CS_PRESENT     = 3'd4;

    // Phases of one bit
    typedef enum logic [1:0] {
        PH_SETUP  = 2'd0,
        PH_ACTIVE = 2'd1,
        PH_HOLD   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0] spi_mode;
        logic       lsb_first;
        logic [7:0] phase_wait;
        logic       cs_active_high;
        logic       cs_present;
    } cfg_t;

    // Result fields, packed into m_tdata from the highest bit down
    typedef struct packed {
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       cs_pin;
        logic       mosi;
        logic       sck;
    } result_t;

    // Bit positions in m_tdata
    localparam int OUT_MOSI_BIT = 1;
    localparam int OUT_DONE_BIT = 11;
    localparam int OUT_BUSY_BIT = 12;

endpackage

/* hw/rtl/spimb_cfg_regs.sv */
`timescale 1ns / 1ps

module spimb_cfg_regs (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output spimb_pkg::cfg_t  cfg
);
    import spimb_pkg::*;

    logic [1:0] spi_mode_reg;
    logic       lsb_first_reg;
    logic [7:0] phase_wait_reg;
    logic       cs_active_high_reg;
    logic       cs_present_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spi_mode_reg       <= 2'd0;
            lsb_first_reg      <= 1'b0;
            phase_wait_reg     <= 8'd0;
            cs_active_high_reg <= 1'b0;
            cs_present_reg     <= 1'b1;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SPI_MODE:       spi_mode_reg       <= pwdata[1:0];
                REG_LSB_FIRST:      lsb_first_reg      <= pwdata[0];
                REG_PHASE_WAIT:     phase_wait_reg     <= pwdata[7:0];
                REG_CS_ACTIVE_HIGH: cs_active_high_reg <= pwdata[0];
                REG_CS_PRESENT:     cs_present_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SPI_MODE:       prdata = {30'd0, spi_mode_reg};
            REG_LSB_FIRST:      prdata = {31'd0, lsb_first_reg};
            REG_PHASE_WAIT:     prdata = {24'd0, phase_wait_reg};
            REG_CS_ACTIVE_HIGH: prdata = {31'd0, cs_active_high_reg};
            REG_CS_PRESENT:     prdata = {31'd0, cs_present_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg = '{spi_mode:       spi_mode_reg,
                   lsb_first:      lsb_first_reg,
                   phase_wait:     phase_wait_reg,
                   cs_active_high: cs_active_high_reg,
                   cs_present:     cs_present_reg};

endmodule

/* hw/rtl/spimb_shifter.sv */
`timescale 1ns / 1ps

module spimb_shifter #(
    parameter int WORD_BITS = spimb_pkg::WORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  spimb_pkg::cfg_t      cfg,
    input  spimb_pkg::action_t   action,
    input  logic [7:0]           tx_byte,
    input  logic                 miso,
    output spimb_pkg::result_t   result
);
    import spimb_pkg::*;

    localparam int CW = $clog2(WORD_BITS);

    logic                 active_reg, active_next;
    phase_t               phase_reg, phase_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [7:0]           wait_reg, wait_next;
    logic [WORD_BITS-1:0] out_reg, out_next;
    logic [WORD_BITS-1:0] in_reg, in_next;
    logic                 sel_reg, sel_next;
    logic                 shown, done;
    logic                 cpol, cpha, at_end, sample;

    assign cpol = cfg.spi_mode[1];
    assign cpha = cfg.spi_mode[0];

    // Next-state logic for one tick
    always_comb begin
        active_next = active_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        wait_next   = wait_reg;
        out_next    = out_reg;
        in_next     = in_reg;
        sel_next    = sel_reg;
        shown       = 1'b0;
        done        = 1'b0;
        at_end      = 1'b0;
        sample      = 1'b0;
        if (active_reg) begin
            shown = 1'b1;
            if (wait_reg < cfg.phase_wait) begin
                wait_next = wait_reg + 8'd1;
            end else begin
                wait_next = 8'd0;
                case (phase_reg)
                    PH_SETUP:  phase_next = PH_ACTIVE;
                    PH_ACTIVE: phase_next = PH_HOLD;
                    default: begin
                        phase_next = PH_SETUP;
                        count_next = count_reg + CW'(1);
                        out_next   = cfg.lsb_first ? (out_reg >> 1) : (out_reg << 1);
                    end
                endcase
            end
            at_end = (wait_next >= cfg.phase_wait);
            sample = at_end && (((phase_next == PH_ACTIVE) && !cpha) ||
                                ((phase_next == PH_HOLD) && cpha));
            if (sample) begin
                in_next = cfg.lsb_first ? {miso, in_reg[WORD_BITS-1:1]}
                                        : {in_reg[WORD_BITS-2:0], miso};
            end
            if (at_end && (phase_next == PH_HOLD) &&
                (count_next >= CW'(WORD_BITS - 1))) begin
                done        = 1'b1;
                active_next = 1'b0;
            end
        end else begin
            case (action)
                ACT_START: begin
                    active_next = 1'b1;
                    phase_next  = PH_SETUP;
                    count_next  = '0;
                    wait_next   = 8'd0;
                    out_next    = WORD_BITS'(tx_byte);
                    in_next     = '0;
                    shown       = 1'b1;
                end
                ACT_SELECT:   sel_next = 1'b1;
                ACT_DESELECT: sel_next = 1'b0;
                default: ;
            endcase
        end
    end

    // Pin levels and flags after the tick
    always_comb begin
        result.sck      = cpol ^ (shown && (phase_next == PH_ACTIVE));
        result.mosi     = shown && (cfg.lsb_first ? out_next[0] : out_next[WORD_BITS-1]);
        result.cs_pin   = cfg.cs_present && (sel_next ? cfg.cs_active_high
                                                      : !cfg.cs_active_high);
        result.rx_byte  = done ? 8'(in_next) : 8'd0;
        result.done_res = done;
        result.busy_res = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            phase_reg  <= PH_SETUP;
            count_reg  <= '0;
            wait_reg   <= 8'd0;
            out_reg    <= '0;
            in_reg     <= '0;
            sel_reg    <= 1'b0;
        end else if (step_en) begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            wait_reg   <= wait_next;
            out_reg    <= out_next;
            in_reg     <= in_next;
            sel_reg    <= sel_next;
        end
    end

endmodule

/* hw/rtl/spi_master_bit_shifter.sv */
`timescale 1ns / 1ps

// Channel  | Ports                         | Payload
// ---------+-------------------------------+---------------------------------------------
// input    | s_tvalid s_tready s_tdata/user| tuser: action; tdata: tx_byte, miso
// result   | m_tvalid m_tready m_tdata     | sck, mosi, cs_pin, rx_byte, done_res, busy_res
// config   | psel penable pwrite paddr ... | spi_mode, lsb_first, phase_wait, cs_*
//
// One tick per cycle while the result channel is not stalled: a transfer lands in
// the input register, and its result is loaded into the output register that drives
// m_tdata. The serial state advances only when the input register hands its tick on;
// a stalled result holds both registers, and s_tready stays high while the result
// register drains. Reset (aresetn low, synchronous) clears all valid flags and
// serial state; chip select comes out of reset released.
module spi_master_bit_shifter #(
    parameter int WORD_BITS = spimb_pkg::WORD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] miso, [15:9] zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] sck, [1] mosi, [2] cs_pin, [10:3] rx_byte,
                                   // [11] done_res, [12] busy_res, [15:13] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import spimb_pkg::*;

    cfg_t       cfg;
    result_t    result;

    logic       in_valid_reg;
    action_t    in_action_reg;
    logic [7:0] in_tx_reg;
    logic       in_miso_reg;
    logic       out_valid_reg;
    logic [15:0] out_data_reg;
    logic       advance;

    assign pready = 1'b1;

    // Hand a tick on when the result register is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload: capture on every accepted transfer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= action_t'(s_tuser);
            in_tx_reg     <= s_tdata[7:0];
            in_miso_reg   <= s_tdata[8];
        end
    end

    spimb_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    spimb_shifter #(
        .WORD_BITS (WORD_BITS)
    ) u_shifter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .cfg     (cfg),
        .action  (in_action_reg),
        .tx_byte (in_tx_reg),
        .miso    (in_miso_reg),
        .result  (result)
    );

    // Result register: load on advance, drop valid once drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {3'd0, result};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hw/rtl/spimb_checker.sv */
`timescale 1ns / 1ps

module spimb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import spimb_pkg::*;

    logic done_bit, busy_bit;

    assign done_bit = m_tdata[OUT_DONE_BIT];
    assign busy_bit = m_tdata[OUT_BUSY_BIT];

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The completing tick ends the transfer
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(done_bit && busy_bit))
        else $error("done and busy together");

    // Received word shows only on completion
    a_rx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !done_bit |-> m_tdata[10:3] == 8'd0)
        else $error("rx_byte nonzero without done");

    // Data line idles low outside a transfer
    a_mosi_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !done_bit && !busy_bit |-> !m_tdata[OUT_MOSI_BIT])
        else $error("mosi driven outside a transfer");

endmodule

bind spi_master_bit_shifter spimb_checker u_spimb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* verif/tb_spi_master_bit_shifter.sv */
`timescale 1ns / 1ps

module tb_spi_master_bit_shifter;
    import spimb_pkg::*;

    // Register slot that decodes to nothing; writes to it must leave the
    // configuration untouched.
    localparam logic [2:0] REG_UNUSED = 3'd7;
    // Length of the long receiver hold-off, in clock cycles.
    localparam int LONG_STALL = 300;
    localparam int LAST_BIT   = WORD_BITS_DEF - 1;

    typedef struct {
        action_t    act;
        logic [7:0] tx;
        logic       miso;
    } tick_item_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;      // [7:0] tx_byte, [8] miso, [15:9] zero
    logic [1:0]  s_tuser = ACT_TICK; // [1:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [0] sck, [1] mosi, [2] cs_pin, [10:3] rx_byte,
                                    // [11] done_res, [12] busy_res, [15:13] zero
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    spi_master_bit_shifter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the serial engine: configuration and shift state
    // ------------------------------------------------------------------
    cfg_t       cfg_sh;
    logic       xfer_on   = 1'b0;
    phase_t     bit_ph    = PH_SETUP;
    logic [2:0] bits_done = '0;
    logic [7:0] wait_cnt  = '0;
    logic [7:0] tx_sr     = '0;
    logic [7:0] rx_sr     = '0;
    logic       cs_sel    = 1'b0;

    tick_item_t tick_q[$];     // ticks waiting to be offered on the input side
    result_t    pin_expect_q[$]; // predicted pin states, oldest first

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  mismatches    = 0;
    int  stall_left    = 0;
    logic stall_req    = 1'b0;
    logic stall_seen   = 1'b0;

    // Advance the shadow engine by one tick and return the pin state after it.
    task automatic shift_tick(input action_t act, input logic [7:0] tx, input logic miso,
                              output result_t r);
        logic shown, done, cpha;
        shown = 1'b0;
        done  = 1'b0;
        cpha  = cfg_sh.spi_mode[0];
        if (xfer_on) begin
            // A tick that starts inside a transfer ignores its action.
            shown = 1'b1;
            if (wait_cnt < cfg_sh.phase_wait) begin
                wait_cnt = wait_cnt + 8'd1;
            end else begin
                // A phase whose count overran a lowered phase_wait ends here too.
                wait_cnt = '0;
                if (bit_ph == PH_HOLD) begin
                    bit_ph    = PH_SETUP;
                    bits_done = bits_done + 3'd1;
                    tx_sr     = cfg_sh.lsb_first ? (tx_sr >> 1) : (tx_sr << 1);
                end else begin
                    bit_ph = phase_t'(bit_ph + 2'd1);
                end
            end
            if (wait_cnt >= cfg_sh.phase_wait) begin
                // Sample on the leading edge in CPHA 0, the trailing edge in CPHA 1.
                if ((bit_ph == PH_ACTIVE && !cpha) || (bit_ph == PH_HOLD && cpha))
                    rx_sr = cfg_sh.lsb_first ? {miso, rx_sr[7:1]} : {rx_sr[6:0], miso};
                if (bit_ph == PH_HOLD && bits_done >= LAST_BIT) begin
                    done    = 1'b1;
                    xfer_on = 1'b0;
                end
            end
        end else begin
            case (act)
                ACT_START: begin
                    xfer_on   = 1'b1;
                    bit_ph    = PH_SETUP;
                    bits_done = '0;
                    wait_cnt  = '0;
                    tx_sr     = tx;
                    rx_sr     = '0;
                    shown     = 1'b1;
                end
                ACT_SELECT:   cs_sel = 1'b1;
                ACT_DESELECT: cs_sel = 1'b0;
                default: ;
            endcase
        end
        r.sck      = cfg_sh.spi_mode[1] ^ (shown && bit_ph == PH_ACTIVE);
        // Drive mosi low whenever no bit of a transfer is on the pin.
        r.mosi     = shown ? (cfg_sh.lsb_first ? tx_sr[0] : tx_sr[7]) : 1'b0;
        // Without a chip select pin the level reads 0 but the selection still tracks.
        r.cs_pin   = cfg_sh.cs_present ? (cs_sel ? cfg_sh.cs_active_high
                                                 : ~cfg_sh.cs_active_high) : 1'b0;
        r.rx_byte  = done ? rx_sr : 8'd0;
        r.done_res = done;
        r.busy_res = xfer_on;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: predict each accepted transfer, then offer the next tick
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : tick_driver
        tick_item_t nxt;
        result_t    pred;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                shift_tick(action_t'(s_tuser), s_tdata[7:0], s_tdata[8], pred);
                pin_expect_q.push_back(pred);
            end
            // Hold an unaccepted tick; otherwise load the next one or idle.
            if (!s_tvalid || s_tready) begin
                if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = tick_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.act;
                    s_tdata  <= {7'd0, nxt.miso, nxt.tx};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver backpressure
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : pin_monitor
        result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[12:0]);
                if (pin_expect_q.size() == 0) begin
                    $error("unexpected result transfer: m_tdata 'h%0h", m_tdata);
                    mismatches++;
                end else begin
                    want = pin_expect_q.pop_front();
                    check_field("sck", want.sck, got.sck);
                    check_field("mosi", want.mosi, got.mosi);
                    check_field("cs_pin", want.cs_pin, got.cs_pin);
                    check_field("rx_byte", want.rx_byte, got.rx_byte);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("tdata pad", 0, m_tdata[15:13]);
                end
            end
            // A toggle of stall_req starts a long hold-off counted here.
            if (stall_req != stall_seen) begin
                stall_seen <= stall_req;
                stall_left <= LONG_STALL;
                m_tready   <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input action_t act, input logic [7:0] tx, input logic miso);
        tick_item_t it;
        it.act  = act;
        it.tx   = tx;
        it.miso = miso;
        tick_q.push_back(it);
    endtask

    // Mostly plain ticks with frequent starts, so transfers run back to back;
    // selects and deselects are mixed in, and land inside transfers too.
    task automatic run_items(input int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            push_item(action_t'(pick < 12 ? ACT_START : pick < 18 ? ACT_SELECT :
                                pick < 24 ? ACT_DESELECT : ACT_TICK),
                      8'($urandom), 1'($urandom));
        end
    endtask

    // Wait until every offered tick is accepted and every result is checked,
    // then let the pipeline settle.
    task automatic drain();
        while (tick_q.size() != 0 || s_tvalid || pin_expect_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where psel, penable, pwrite and pready are all high.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_SPI_MODE:       cfg_sh.spi_mode       = val[1:0];
            REG_LSB_FIRST:      cfg_sh.lsb_first      = val[0];
            REG_PHASE_WAIT:     cfg_sh.phase_wait     = val[7:0];
            REG_CS_ACTIVE_HIGH: cfg_sh.cs_active_high = val[0];
            REG_CS_PRESENT:     cfg_sh.cs_present     = val[0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_cfg(input logic [1:0] mode, input logic lsb, input logic [7:0] pw,
                             input logic cs_high, input logic cs_pres);
        write_reg(REG_SPI_MODE, {30'd0, mode});
        write_reg(REG_LSB_FIRST, {31'd0, lsb});
        write_reg(REG_PHASE_WAIT, {24'd0, pw});
        write_reg(REG_CS_ACTIVE_HIGH, {31'd0, cs_high});
        write_reg(REG_CS_PRESENT, {31'd0, cs_pres});
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_sh.spi_mode       = 2'd0;
        cfg_sh.lsb_first      = 1'b0;
        cfg_sh.phase_wait     = 8'd0;
        cfg_sh.cs_active_high = 1'b0;
        cfg_sh.cs_present     = 1'b1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset configuration, select with a plain tick, a full
        // 0xFF transfer with toggling miso, and start/select/deselect issued
        // while busy, which the engine must ignore.
        push_item(ACT_SELECT, 8'h00, 1'b0);
        push_item(ACT_TICK, 8'hFF, 1'b1);
        push_item(ACT_START, 8'hFF, 1'b1);
        for (int i = 0; i < 24; i++)
            push_item(action_t'(i == 3 ? ACT_START : i == 7 ? ACT_DESELECT :
                                i == 11 ? ACT_SELECT : ACT_TICK), 8'h00, 1'(i));
        push_item(ACT_DESELECT, 8'h00, 1'b0);
        drain();

        // Sender sparse idling, receiver heavy idling.
        send_idle_pct = 27;
        recv_idle_pct = 83;
        apply_cfg(2'd1, 1'b1, 8'd1, 1'b1, 1'b1);
        run_items(180);
        drain();

        // No chip select pin; stall the receiver long enough to back up the
        // input while ticks keep coming, and poke the undecoded register.
        write_reg(REG_UNUSED, $urandom);
        apply_cfg(2'd2, 1'b0, 8'd3, 1'b0, 1'b0);
        run_items(180);
        @(posedge aclk);
        stall_req <= ~stall_req;
        drain();

        // Swap the idling; hold the sender halfway until all results are in.
        send_idle_pct = 83;
        recv_idle_pct = 27;
        apply_cfg(2'd3, 1'b1, 8'd0, 1'b1, 1'b1);
        run_items(90);
        drain();
        run_items(90);
        drain();

        apply_cfg(2'($urandom), 1'($urandom), 8'($urandom_range(2)),
                  1'($urandom), 1'($urandom));
        run_items(180);
        drain();

        // No idling: longest phases leave a transfer mid-bit, then drop
        // phase_wait to zero so the overrun phase ends at once.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_cfg(2'd0, 1'b0, 8'd255, 1'b1, 1'b1);
        push_item(ACT_START, 8'($urandom), 1'b0);
        run_items(199);
        drain();
        apply_cfg(2'd0, 1'b1, 8'd0, 1'b0, 1'b1);
        run_items(150);
        drain();

        repeat (10) @(posedge aclk);
        if (pin_expect_q.size() != 0) begin
            $error("%0d results never arrived", pin_expect_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("spi_master_bit_shifter regression: pass");
        end else begin
            $display("spi_master_bit_shifter regression: fail");
        end
        $finish;
    end

    // Watchdog: drop the run if it hangs.
    initial begin
        #400000;
        $display("spi_master_bit_shifter regression: fail");
        $finish;
    end

endmodule
